// ===== hdl/cas_pkg.sv =====
// Shared types for the collision avoidance steering core.
// Holds datapath op codes, lane groups, register indexes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package cas_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 31;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL     = 1'd1;

    localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_CAPTURE   = 4'd1,
        OP_MUL       = 4'd2,
        OP_ACC       = 4'd3,
        OP_SQ_START  = 4'd4,
        OP_SQ_STEP   = 4'd5,
        OP_DIV_START = 4'd6,
        OP_DIV_STEP  = 4'd7,
        OP_DECIDE    = 4'd8,
        OP_EMIT      = 4'd9,
        OP_MAG       = 4'd10,
        OP_NORM      = 4'd11,
        OP_STORE     = 4'd12,
        OP_OUT       = 4'd13
    } op_t;

    // operand group of the shared multiplier
    typedef enum logic [2:0] {
        G_DV2 = 3'd0,   // dv_i * dv_i
        G_DP2 = 3'd1,   // dp_i * dp_i
        G_DOT = 3'd2,   // dp_i * dv_i
        G_VT  = 3'd3,   // best_vel_i * best_time
        G_M2  = 3'd4,   // m_i * m_i
        G_MA  = 3'd5,   // m_i * max_accel
        G_ST  = 3'd6    // speed * t
    } grp_t;

    typedef struct packed {
        op_t        op;
        grp_t       grp;
        logic [1:0] lane;
        logic       sq_src_p;   // sqrt of squared distance instead of speed
    } cmd_t;

    typedef struct packed {
        logic act;
        logic last;
        logic ssv_zero;
        logic have_best;
        logic dir_pos;
        logic need_norm;
        logic len_zero;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/cas_ctrl.sv =====
// Sequencer of the collision avoidance steering core.
// Issues at most one datapath op per cycle, none while it waits for a free output register; uses cas_pkg.
`default_nettype none

module cas_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  cas_pkg::sts_t      sts,
    output cas_pkg::cmd_t      cmd
);
    import cas_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_DISP      = 16'h0002,
        S_MUL       = 16'h0004,
        S_ACC       = 16'h0008,
        S_CHK       = 16'h0010,
        S_SQ_START  = 16'h0020,
        S_SQ_RUN    = 16'h0040,
        S_DIV_START = 16'h0080,
        S_DIV_RUN   = 16'h0100,
        S_DECIDE    = 16'h0200,
        S_EMIT      = 16'h0400,
        S_MAG       = 16'h0800,
        S_NORM      = 16'h1000,
        S_LEN_CHK   = 16'h2000,
        S_STORE     = 16'h4000,
        S_OUT       = 16'h8000
    } state_t;

    typedef enum logic [1:0] {
        SQ_SPEED = 2'd0,
        SQ_DIST  = 2'd1,
        SQ_LEN   = 2'd2
    } sq_t;

    state_t     state_reg, state_next;
    grp_t       grp_reg, grp_next;
    logic [1:0] lane_reg, lane_next;
    logic [4:0] cnt_reg, cnt_next;
    sq_t        sq_reg, sq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            grp_reg   <= G_DV2;
            lane_reg  <= 2'd0;
            cnt_reg   <= 5'd0;
            sq_reg    <= SQ_SPEED;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
            lane_reg  <= lane_next;
            cnt_reg   <= cnt_next;
            sq_reg    <= sq_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        grp_next     = grp_reg;
        lane_next    = lane_reg;
        cnt_next     = cnt_reg;
        sq_next      = sq_reg;
        cmd.op       = OP_NONE;
        cmd.grp      = grp_reg;
        cmd.lane     = lane_reg;
        cmd.sq_src_p = (sq_reg == SQ_DIST);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                grp_next   = G_DV2;
                lane_next  = 2'd0;
                state_next = sts.act ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                case (grp_reg)
                    G_MA:    state_next = S_DIV_START;
                    G_ST:    state_next = S_DECIDE;
                    default:
                    begin
                        if (lane_reg != 2'd2)
                        begin
                            lane_next  = lane_reg + 2'd1;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            lane_next = 2'd0;
                            case (grp_reg)
                                G_DV2:
                                begin
                                    grp_next   = G_DP2;
                                    state_next = S_MUL;
                                end
                                G_DP2:
                                begin
                                    grp_next   = G_DOT;
                                    state_next = S_MUL;
                                end
                                G_DOT:   state_next = S_CHK;
                                G_VT:    state_next = S_MAG;
                                default:
                                begin
                                    sq_next    = SQ_LEN;
                                    state_next = S_SQ_START;
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_CHK:
            begin
                sq_next = SQ_SPEED;
                if (sts.ssv_zero)
                    state_next = sts.last ? S_EMIT : S_IDLE;
                else
                    state_next = S_SQ_START;
            end
            S_SQ_START:
            begin
                cmd.op     = OP_SQ_START;
                cnt_next   = 5'd0;
                state_next = S_SQ_RUN;
            end
            S_SQ_RUN:
            begin
                cmd.op   = OP_SQ_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    case (sq_reg)
                        SQ_SPEED:
                        begin
                            sq_next    = SQ_DIST;
                            state_next = S_SQ_START;
                        end
                        SQ_DIST: state_next = S_DIV_START;
                        default: state_next = S_LEN_CHK;
                    endcase
                end
            end
            S_DIV_START:
            begin
                cmd.op     = OP_DIV_START;
                cnt_next   = 5'd0;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    if (grp_reg == G_MA)
                        state_next = S_STORE;
                    else
                    begin
                        grp_next   = G_ST;
                        state_next = S_MUL;
                    end
                end
            end
            S_DECIDE:
            begin
                cmd.op     = OP_DECIDE;
                state_next = sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                cmd.op    = OP_EMIT;
                grp_next  = G_VT;
                lane_next = 2'd0;
                if (!sts.have_best)
                    state_next = S_OUT;
                else if (sts.dir_pos)
                    state_next = S_MAG;
                else
                    state_next = S_MUL;
            end
            S_MAG:
            begin
                cmd.op     = OP_MAG;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (sts.need_norm)
                    cmd.op = OP_NORM;
                else
                begin
                    grp_next   = G_M2;
                    lane_next  = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_LEN_CHK:
            begin
                grp_next   = G_MA;
                lane_next  = 2'd0;
                state_next = sts.len_zero ? S_OUT : S_MUL;
            end
            S_STORE:
            begin
                cmd.op = OP_STORE;
                if (lane_reg == 2'd2)
                    state_next = S_OUT;
                else
                begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/cas_datapath.sv =====
// Datapath of the collision avoidance steering core: vector registers,
// shared multiplier, iterative square root and divider, output register.
// Driven by cas_ctrl commands; uses cas_pkg.
`default_nettype none

module cas_datapath #(
    parameter int FRAC_BITS = cas_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  cas_pkg::cmd_t                       cmd,
    output cas_pkg::sts_t                       sts,
    input  wire logic                           cfg_we,
    input  wire logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cas_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           action,
    input  wire logic signed [31:0]             pos_x,
    input  wire logic signed [31:0]             pos_y,
    input  wire logic signed [31:0]             pos_z,
    input  wire logic signed [31:0]             vel_x,
    input  wire logic signed [31:0]             vel_y,
    input  wire logic signed [31:0]             vel_z,
    input  wire logic                           last_target,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [31:0]                  accel_x,
    output logic signed [31:0]                  accel_y,
    output logic signed [31:0]                  accel_z,
    output logic                                found
);
    import cas_pkg::*;

    // divider width: numerator up to 2^(64+FRAC), divisor shifted by 31
    localparam int LW = 96 + FRAC_BITS;

    function automatic logic [31:0] sat33(input logic [32:0] d);
        if (d[32] != d[31])
            return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return d[31:0];
    endfunction

    function automatic logic [31:0] sat66(input logic [65:0] s);
        if ((&s[65:31]) || !(|s[65:31]))
            return s[31:0];
        return s[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    logic [30:0]        radius_reg, max_accel_reg;
    logic [31:0]        char_pos_reg [3];
    logic [31:0]        char_vel_reg [3];
    logic               act_reg, last_reg;
    logic [31:0]        dp_reg [3];
    logic [31:0]        dv_reg [3];
    logic signed [65:0] prod_reg;
    logic signed [65:0] acc_v_reg, acc_p_reg, acc_d_reg;
    // square root unit
    logic [63:0]        rad_reg;
    logic [35:0]        rem_reg;
    logic [31:0]        root_reg, speed_reg;
    // divider unit
    logic [LW-1:0]      drem_reg, dsh_reg;
    logic [30:0]        q_reg;
    logic               dsat_reg;
    // kept target
    logic               have_best_reg;
    logic [30:0]        best_time_reg;
    logic [31:0]        best_min_sep_reg, best_dist_reg;
    logic [31:0]        best_pos_reg [3];
    logic [31:0]        best_vel_reg [3];
    // result build
    logic [63:0]        v_reg [3];
    logic [63:0]        m_reg [3];
    logic               sgn_reg [3];
    logic [31:0]        a_reg [3];
    logic               out_valid_reg;
    logic [31:0]        out_x_reg, out_y_reg, out_z_reg;
    logic               found_reg;

    logic [31:0]        in_pos [3];
    logic [31:0]        in_vel [3];
    logic signed [32:0] mul_a, mul_b;
    logic [31:0]        two_r;
    logic [30:0]        div_t;
    logic [65:0]        neg_dot;
    logic [LW-1:0]      dnum, dden;
    logic [35:0]        rem_sh, trial;
    logic signed [65:0] prod_sh, sep;
    logic               keep;
    logic [31:0]        m_lo;

    assign in_pos = '{pos_x, pos_y, pos_z};
    assign in_vel = '{vel_x, vel_y, vel_z};
    assign two_r  = {radius_reg, 1'b0};
    assign div_t  = dsat_reg ? TIME_MAX : q_reg;
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign m_lo   = {1'b0, m_reg[cmd.lane][30:0]};

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.grp)
            G_DV2:
            begin
                mul_a = {dv_reg[cmd.lane][31], dv_reg[cmd.lane]};
                mul_b = mul_a;
            end
            G_DP2:
            begin
                mul_a = {dp_reg[cmd.lane][31], dp_reg[cmd.lane]};
                mul_b = mul_a;
            end
            G_DOT:
            begin
                mul_a = {dp_reg[cmd.lane][31], dp_reg[cmd.lane]};
                mul_b = {dv_reg[cmd.lane][31], dv_reg[cmd.lane]};
            end
            G_VT:
            begin
                mul_a = {best_vel_reg[cmd.lane][31], best_vel_reg[cmd.lane]};
                mul_b = {2'b00, best_time_reg};
            end
            G_M2:
            begin
                mul_a = {1'b0, m_lo};
                mul_b = {1'b0, m_lo};
            end
            G_MA:
            begin
                mul_a = {1'b0, m_lo};
                mul_b = {2'b00, max_accel_reg};
            end
            G_ST:
            begin
                mul_a = {1'b0, speed_reg};
                mul_b = {2'b00, div_t};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operands
    always_comb
    begin
        neg_dot = -acc_d_reg;
        if (cmd.grp == G_MA)
        begin
            dnum = LW'(prod_reg[61:0]);
            dden = LW'(root_reg);
        end
        else
        begin
            dnum = acc_d_reg[65] ? (LW'(neg_dot[63:0]) << FRAC_BITS) : '0;
            dden = LW'(acc_v_reg[63:0]);
        end
    end

    assign rem_sh = {rem_reg[33:0], rad_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};

    assign sep  = $signed({34'd0, root_reg}) - prod_sh;
    assign keep = !(sep > $signed({34'd0, two_r})) && (div_t != '0) &&
                  (!have_best_reg || (div_t < best_time_reg));

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= 31'h0001_0000;
            max_accel_reg <= 31'h0001_0000;
            have_best_reg <= 1'b0;
            best_time_reg <= TIME_MAX;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                char_pos_reg[i] <= '0;
                char_vel_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TARGET_RADIUS: radius_reg    <= cfg_data;
                    REG_MAX_ACCEL:     max_accel_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (cmd.op == OP_CAPTURE && !action)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    char_pos_reg[i] <= in_pos[i];
                    char_vel_reg[i] <= in_vel[i];
                end
            end
            if (cmd.op == OP_DECIDE && keep)
            begin
                have_best_reg <= 1'b1;
                best_time_reg <= div_t;
            end
            if (cmd.op == OP_OUT)
            begin
                have_best_reg <= 1'b0;
                best_time_reg <= TIME_MAX;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                act_reg   <= action;
                last_reg  <= last_target;
                acc_v_reg <= '0;
                acc_p_reg <= '0;
                acc_d_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    dp_reg[i] <= sat33({in_pos[i][31], in_pos[i]} -
                                       {char_pos_reg[i][31], char_pos_reg[i]});
                    dv_reg[i] <= sat33({in_vel[i][31], in_vel[i]} -
                                       {char_vel_reg[i][31], char_vel_reg[i]});
                end
            end
            OP_MUL: prod_reg <= mul_a * mul_b;
            OP_ACC:
            begin
                case (cmd.grp)
                    G_DV2, G_M2: acc_v_reg <= acc_v_reg + prod_reg;
                    G_DP2:       acc_p_reg <= acc_p_reg + prod_reg;
                    G_DOT:       acc_d_reg <= acc_d_reg + prod_reg;
                    G_VT:
                        v_reg[cmd.lane] <= {{32{best_pos_reg[cmd.lane][31]}},
                                            best_pos_reg[cmd.lane]} + prod_sh[63:0];
                    default:     ;
                endcase
            end
            OP_SQ_START:
            begin
                rad_reg  <= cmd.sq_src_p ? acc_p_reg[63:0] : acc_v_reg[63:0];
                rem_reg  <= '0;
                root_reg <= '0;
                if (cmd.sq_src_p)
                    speed_reg <= root_reg;
            end
            OP_SQ_STEP:
            begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            OP_DIV_START:
            begin
                drem_reg <= dnum;
                dsh_reg  <= dden << 30;
                dsat_reg <= (dnum >= (dden << 31));
                q_reg    <= '0;
            end
            OP_DIV_STEP:
            begin
                dsh_reg <= dsh_reg >> 1;
                if (drem_reg >= dsh_reg)
                begin
                    drem_reg <= drem_reg - dsh_reg;
                    q_reg    <= {q_reg[29:0], 1'b1};
                end
                else
                    q_reg <= {q_reg[29:0], 1'b0};
            end
            OP_DECIDE:
            begin
                if (keep)
                begin
                    best_min_sep_reg <= sat66(sep);
                    best_dist_reg    <= root_reg[31] ? 32'h7FFF_FFFF : root_reg;
                    for (int i = 0; i < 3; i++)
                    begin
                        best_pos_reg[i] <= dp_reg[i];
                        best_vel_reg[i] <= dv_reg[i];
                    end
                end
            end
            OP_EMIT:
            begin
                acc_v_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i] <= '0;
                    v_reg[i] <= {{32{best_pos_reg[i][31]}}, best_pos_reg[i]};
                end
            end
            OP_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sgn_reg[i] <= v_reg[i][63];
                    m_reg[i]   <= v_reg[i][63] ? -v_reg[i] : v_reg[i];
                end
            end
            OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                    m_reg[i] <= m_reg[i] >> 1;
            end
            OP_STORE:
                a_reg[cmd.lane] <= sgn_reg[cmd.lane] ? -{1'b0, q_reg} : {1'b0, q_reg};
            OP_OUT:
            begin
                out_x_reg <= a_reg[0];
                out_y_reg <= a_reg[1];
                out_z_reg <= a_reg[2];
                found_reg <= have_best_reg;
            end
            default: ;
        endcase
    end

    assign sts.act       = act_reg;
    assign sts.last      = last_reg;
    assign sts.ssv_zero  = (acc_v_reg == '0);
    assign sts.have_best = have_best_reg;
    assign sts.dir_pos   = ($signed(best_min_sep_reg) <= 0) || (best_dist_reg < two_r);
    assign sts.need_norm = (|m_reg[0][63:31]) || (|m_reg[1][63:31]) || (|m_reg[2][63:31]);
    assign sts.len_zero  = (root_reg == '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign accel_x   = out_x_reg;
    assign accel_y   = out_y_reg;
    assign accel_z   = out_z_reg;
    assign found     = found_reg;

endmodule

`default_nettype wire

// ===== hdl/collision_avoidance_steering_core.sv =====
// Top level of the collision avoidance steering core.
// Joins cas_ctrl (sequencer) and cas_datapath; uses cas_pkg.
//
// A beat with action 0 loads the character position and velocity. A beat
// with action 1 is one target: relative vectors, squared lengths and dot
// product on one shared 33x33 multiplier (9 products), then, unless the
// relative speed is zero, two 32-step square roots (speed, distance), a
// 31-step restoring divide for the time of closest approach and the
// separation test. The serial root and divide units keep the core busy, so
// the next beat is taken only once a target is done. A target beat with
// last_target set then builds the result: the avoidance direction, a
// normalizing shift of one bit per cycle, a third square root and three
// divides. One result beat (found, accel_x/y/z in signed Q16.16) follows
// each last target; a list with no threatening target gives found 0 and
// zero acceleration. The result sits in an output register, so the next
// input beat is taken while it waits. Configuration (target_radius at index 0,
// max_accel at index 1) must be written only while the core is idle (not enforced).
`default_nettype none

module collision_avoidance_steering_core #(
    parameter int FRAC_BITS = cas_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cas_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic signed [31:0]             pos_x,
    input  wire logic signed [31:0]             pos_y,
    input  wire logic signed [31:0]             pos_z,
    input  wire logic signed [31:0]             vel_x,
    input  wire logic signed [31:0]             vel_y,
    input  wire logic signed [31:0]             vel_z,
    input  wire logic                           last_target,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [31:0]                  accel_x,
    output logic signed [31:0]                  accel_y,
    output logic signed [31:0]                  accel_z,
    output logic                                found
);
    import cas_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: at most one op per cycle, none while it waits for a free output register
    cas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // vectors, shared arithmetic units, kept target, result register
    cas_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (action),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .vel_z       (vel_z),
        .last_target (last_target),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .found       (found)
    );

`ifndef SYNTHESIS
    // an accepted beat always starts work, so the core is busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // no threat means no steering
    a_no_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (accel_x == 0) && (accel_y == 0) && (accel_z == 0))
        else $error("acceleration without a kept target");

    // a new result is loaded only into a free output register
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |-> sts.out_free)
        else $error("result overwrites a pending beat");
`endif

endmodule

`default_nettype wire
